// ===== rtl/core/grt_pkg.sv =====
// shared types and constants for the guarded region table
`timescale 1ns / 1ps
package grt_pkg;

	localparam int FIELD_W        = 48;
	localparam int OWNER_W        = 48;
	localparam int SIZE_W         = 32;
	localparam int DEF_ENTRIES    = 64;
	localparam int DEF_WORD_BYTES = 8;
	localparam int DEF_ADDR_BITS  = 48;

	localparam logic [2:0] OP_GUARD   = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_QUERY   = 3'd2;
	localparam logic [2:0] OP_ADD     = 3'd3;
	localparam logic [2:0] OP_REMOVE  = 3'd4;
	localparam logic [2:0] OP_VERIFY  = 3'd5;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FULL      = 3'd1;
	localparam logic [2:0] ST_OVERLAP   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_BASE  = 3'd4;
	localparam logic [2:0] ST_OWNER     = 3'd5;
	localparam logic [2:0] ST_BOUNDS    = 3'd6;

	typedef enum logic [1:0] {
		SEL_HOLD,
		SEL_NEXT,
		SEL_PREV,
		SEL_NEW
	} cell_sel_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE,
		S_FINISH
	} grt_state_t;

	typedef struct packed {
		logic ovl;
		logic hit;
		logic r_found;
		logic r_base_eq;
		logic s_found;
		logic s_owner_ok;
		logic s_bound_ok;
	} scan_flags_t;

endpackage

// ===== rtl/core/grt_cell.sv =====
// one table cell holding an entry, shifting to or from its neighbors
`timescale 1ns / 1ps
module grt_cell import grt_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  cell_sel_t    sel,
	input  logic [W-1:0] next_d,
	input  logic [W-1:0] prev_d,
	input  logic [W-1:0] new_d,
	output logic [W-1:0] q
);

	logic [W-1:0] d_q;

	always_ff @(posedge clk) begin
		unique case (sel)
			SEL_HOLD: d_q <= d_q;
			SEL_NEXT: d_q <= next_d;
			SEL_PREV: d_q <= prev_d;
			SEL_NEW:  d_q <= new_d;
			default:  d_q <= d_q;
		endcase
	end

	assign q = d_q;

endmodule

// ===== rtl/core/grt_scan.sv =====
// compare unit at the head of both chains, accumulating scan results
`timescale 1ns / 1ps
module grt_scan import grt_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int WORD_BYTES = DEF_WORD_BYTES,
	parameter int AW         = DEF_ADDR_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               step,
	input  logic [$clog2(ENTRIES)-1:0]         idx,
	input  logic [$clog2(ENTRIES+1)-1:0]       rcnt,
	input  logic [$clog2(ENTRIES+1)-1:0]       scnt,
	input  logic [2:0]                         op,
	input  logic [AW-1:0]                      base,
	input  logic [SIZE_W-1:0]                  size,
	input  logic [OWNER_W-1:0]                 owner,
	input  logic [AW-1:0]                      acc,
	input  logic [AW-1:0]                      rh_base,
	input  logic [SIZE_W-1:0]                  rh_len,
	input  logic [AW-1:0]                      sh_base,
	input  logic [SIZE_W-1:0]                  sh_words,
	input  logic [OWNER_W-1:0]                 sh_owner,
	output scan_flags_t                        flags,
	output logic [$clog2(ENTRIES+1)-1:0]       ins_pos,
	output logic [$clog2(ENTRIES)-1:0]         r_idx,
	output logic [$clog2(ENTRIES)-1:0]         s_idx
);

	localparam int IW    = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES+1);
	localparam int LEN_W = SIZE_W + $clog2(WORD_BYTES+1);
	localparam int CW    = (AW > LEN_W) ? AW : LEN_W;

	function automatic logic before_end(input logic [AW-1:0] x, input logic [AW-1:0] b,
			input logic [LEN_W-1:0] len);
		logic [AW-1:0] d;
		d = x - b;
		return (x < b) || (CW'(d) < CW'(len));
	endfunction

	function automatic logic span_has(input logic [AW-1:0] x, input logic [AW-1:0] b,
			input logic [LEN_W-1:0] len);
		logic [AW-1:0] d;
		d = x - b;
		return (x >= b) && (CW'(d) < CW'(len));
	endfunction

	scan_flags_t          flags_q;
	logic [CNT_W-1:0]     pos_q;
	logic [IW-1:0]        r_idx_q;
	logic [IW-1:0]        s_idx_q;
	logic                 rv;
	logic                 sv;
	logic [LEN_W-1:0]     new_len;
	logic [LEN_W-1:0]     r_len;
	logic [LEN_W-1:0]     s_bytes;
	logic                 r_ovl;
	logic                 s_ovl;
	logic                 r_has;
	logic                 s_has;
	logic [AW-1:0]        acc_off;

	always_comb begin
		rv      = CNT_W'(idx) < rcnt;
		sv      = CNT_W'(idx) < scnt;
		r_len   = LEN_W'(rh_len);
		s_bytes = LEN_W'(sh_words) * LEN_W'(WORD_BYTES);
		new_len = (op == OP_ADD) ? LEN_W'(size) * LEN_W'(WORD_BYTES) : LEN_W'(size);
		r_ovl   = rv && before_end(rh_base, base, new_len) && before_end(base, rh_base, r_len);
		s_ovl   = sv && before_end(sh_base, base, new_len) && before_end(base, sh_base, s_bytes);
		r_has   = rv && span_has(base, rh_base, r_len);
		s_has   = sv && span_has(base, sh_base, s_bytes);
		acc_off = acc - base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			pos_q   <= '0;
			r_idx_q <= '0;
			s_idx_q <= '0;
		end else if (start) begin
			flags_q <= '0;
			pos_q   <= '0;
			r_idx_q <= '0;
			s_idx_q <= '0;
		end else if (step) begin
			if (r_ovl || s_ovl)
				flags_q.ovl <= 1'b1;
			if (r_has || s_has)
				flags_q.hit <= 1'b1;
			if (rv && (rh_base <= base))
				pos_q <= pos_q + 1'b1;
			if (!flags_q.r_found && r_has) begin
				flags_q.r_found   <= 1'b1;
				flags_q.r_base_eq <= (rh_base == base);
				r_idx_q           <= idx;
			end
			if (!flags_q.s_found && sv && (sh_base == base)) begin
				flags_q.s_found    <= 1'b1;
				flags_q.s_owner_ok <= (sh_owner == owner);
				flags_q.s_bound_ok <= (acc >= base) && (CW'(acc_off) < CW'(s_bytes));
				s_idx_q            <= idx;
			end
		end
	end

	assign flags   = flags_q;
	assign ins_pos = pos_q;
	assign r_idx   = r_idx_q;
	assign s_idx   = s_idx_q;

endmodule

// ===== rtl/core/guarded_region_table.sv =====
// top level of the guarded region table: two rotating chains of entry cells
// a result follows one full rotation of the cell chains past the head compare unit,
// then the update state and a finish state that waits until the output register is free
// one transaction in flight: a new request is taken only once the block is idle again
// reset: both tables empty, no result pending; entry contents are not cleared
`timescale 1ns / 1ps
module guarded_region_table import grt_pkg::*; #(
	parameter int ENTRIES    = DEF_ENTRIES,
	parameter int WORD_BYTES = DEF_WORD_BYTES,
	parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [2:0]         op,
	input  logic [FIELD_W-1:0] base_addr,
	input  logic [SIZE_W-1:0]  region_size,
	input  logic [OWNER_W-1:0] owner_tag,
	input  logic [FIELD_W-1:0] access_addr,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic               hit
);

	localparam int AW    = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
	localparam int IW    = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES+1);
	localparam int RW    = AW + SIZE_W;
	localparam int SW    = AW + SIZE_W + OWNER_W;

	grt_state_t          state_q, state_d;
	logic [2:0]          op_q;
	logic [AW-1:0]       base_q;
	logic [SIZE_W-1:0]   size_q;
	logic [OWNER_W-1:0]  owner_q;
	logic [AW-1:0]       acc_q;
	logic [IW-1:0]       k_q;
	logic [CNT_W-1:0]    rcnt_q;
	logic [CNT_W-1:0]    scnt_q;
	logic [2:0]          res_status_q;
	logic                res_hit_q;
	logic                rsp_valid_q;
	logic [2:0]          status_q;
	logic                hit_q;

	logic                accept;
	logic                scan_last;
	logic                in_scan;
	logic                in_update;
	logic                load_out;
	logic                r_ins;
	logic                r_del;
	logic                s_add;
	logic                s_del;
	logic [2:0]          upd_status;

	scan_flags_t         flags;
	logic [CNT_W-1:0]    ins_pos;
	logic [IW-1:0]       r_idx;
	logic [IW-1:0]       s_idx;

	logic [RW-1:0]       rcell  [ENTRIES];
	logic [SW-1:0]       scell  [ENTRIES];
	cell_sel_t           rsel   [ENTRIES];
	cell_sel_t           ssel   [ENTRIES];

	assign accept    = req_valid && !req_stall;
	assign scan_last = (k_q == IW'(ENTRIES-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		in_scan   = 1'b0;
		in_update = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid)
					state_d = S_SCAN;
			end
			S_SCAN: begin
				in_scan = 1'b1;
				if (scan_last)
					state_d = S_UPDATE;
			end
			S_UPDATE: begin
				in_update = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		upd_status = ST_OK;
		r_ins      = 1'b0;
		r_del      = 1'b0;
		s_add      = 1'b0;
		s_del      = 1'b0;
		unique case (op_q)
			OP_GUARD: begin
				if (rcnt_q >= CNT_W'(ENTRIES))
					upd_status = ST_FULL;
				else if (flags.ovl)
					upd_status = ST_OVERLAP;
				else
					r_ins = in_update;
			end
			OP_RELEASE: begin
				if (!flags.r_found)
					upd_status = ST_NOT_FOUND;
				else if (!flags.r_base_eq)
					upd_status = ST_NOT_BASE;
				else
					r_del = in_update;
			end
			OP_ADD: begin
				if (scnt_q >= CNT_W'(ENTRIES-1))
					upd_status = ST_FULL;
				else if (flags.ovl)
					upd_status = ST_OVERLAP;
				else
					s_add = in_update;
			end
			OP_REMOVE: begin
				if (!flags.s_found)
					upd_status = ST_NOT_FOUND;
				else if (!flags.s_owner_ok)
					upd_status = ST_OWNER;
				else
					s_del = in_update;
			end
			OP_VERIFY: begin
				if (!flags.s_found)
					upd_status = ST_NOT_FOUND;
				else if (!flags.s_owner_ok)
					upd_status = ST_OWNER;
				else if (!flags.s_bound_ok)
					upd_status = ST_BOUNDS;
			end
			default: upd_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			base_q  <= base_addr[AW-1:0];
			size_q  <= region_size;
			owner_q <= owner_tag;
			acc_q   <= access_addr[AW-1:0];
		end
		if (in_update) begin
			res_status_q <= upd_status;
			res_hit_q    <= (op_q == OP_QUERY) && flags.hit;
		end
		if (load_out) begin
			status_q <= res_status_q;
			hit_q    <= res_hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			rcnt_q      <= '0;
			scnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (in_scan)
				k_q <= scan_last ? '0 : k_q + 1'b1;
			if (r_ins)
				rcnt_q <= rcnt_q + 1'b1;
			else if (r_del)
				rcnt_q <= rcnt_q - 1'b1;
			if (s_add)
				scnt_q <= scnt_q + 1'b1;
			else if (s_del)
				scnt_q <= scnt_q - 1'b1;
			if (load_out)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cells
		always_comb begin
			priority if (in_scan)
				rsel[i] = SEL_NEXT;
			else if (r_ins && (CNT_W'(i) == ins_pos))
				rsel[i] = SEL_NEW;
			else if (r_ins && (CNT_W'(i) > ins_pos))
				rsel[i] = SEL_PREV;
			else if (r_del && (IW'(i) >= r_idx))
				rsel[i] = SEL_NEXT;
			else
				rsel[i] = SEL_HOLD;

			priority if (in_scan)
				ssel[i] = SEL_NEXT;
			else if (s_add && (IW'(i) == scnt_q[IW-1:0]))
				ssel[i] = SEL_NEW;
			else if (s_del && (IW'(i) >= s_idx))
				ssel[i] = SEL_NEXT;
			else
				ssel[i] = SEL_HOLD;
		end

		grt_cell #(.W(RW)) u_rcell (
			.clk    (clk),
			.sel    (rsel[i]),
			.next_d (rcell[(i+1) % ENTRIES]),
			.prev_d (rcell[(i+ENTRIES-1) % ENTRIES]),
			.new_d  ({base_q, size_q}),
			.q      (rcell[i])
		);

		grt_cell #(.W(SW)) u_scell (
			.clk    (clk),
			.sel    (ssel[i]),
			.next_d (scell[(i+1) % ENTRIES]),
			.prev_d (scell[(i+ENTRIES-1) % ENTRIES]),
			.new_d  ({base_q, size_q, owner_q}),
			.q      (scell[i])
		);
	end

	grt_scan #(
		.ENTRIES    (ENTRIES),
		.WORD_BYTES (WORD_BYTES),
		.AW         (AW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.step     (in_scan),
		.idx      (k_q),
		.rcnt     (rcnt_q),
		.scnt     (scnt_q),
		.op       (op_q),
		.base     (base_q),
		.size     (size_q),
		.owner    (owner_q),
		.acc      (acc_q),
		.rh_base  (rcell[0][RW-1:SIZE_W]),
		.rh_len   (rcell[0][SIZE_W-1:0]),
		.sh_base  (scell[0][SW-1:SIZE_W+OWNER_W]),
		.sh_words (scell[0][SIZE_W+OWNER_W-1:OWNER_W]),
		.sh_owner (scell[0][OWNER_W-1:0]),
		.flags    (flags),
		.ins_pos  (ins_pos),
		.r_idx    (r_idx),
		.s_idx    (s_idx)
	);

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign hit       = hit_q;

endmodule
